// ===== rtl/tavg_pkg.sv =====
// ----------------------------------------------------------------------------
// tavg_pkg
// Shared widths, segment codes and the word passed from the averaging stage
// to the display stage.
// ----------------------------------------------------------------------------
package tavg_pkg;

   localparam int SUM_W     = 16;  // running sum of half degrees
   localparam int COUNT_W   = 6;   // readings taken since the last average
   localparam int MAG_W     = 14;  // |sum| never exceeds 63 * 256
   localparam int SCALED_W  = 17;  // |sum| * 5
   localparam int TENTHS_W  = 11;  // average magnitude in tenths, at most 1280
   localparam int DIGIT_W   = 4;
   localparam int SEG_W     = 8;

   localparam logic [SEG_W-1:0] SEG_MINUS = 8'hBF;
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [TENTHS_W-1:0] tenths;    // latched average magnitude
      logic                negative;  // latched average sign
      logic                led;       // status LED level
      logic                fresh;     // this word carried a new average
   } avg_word_type;

   // active-low segments; codes above nine show blank
   function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

// ===== rtl/tavg_accum.sv =====
// ----------------------------------------------------------------------------
// tavg_accum
// Input register, running sum and sample count, and the divide of the sum
// by SAMPLES that forms the average in tenths of a degree.
// ----------------------------------------------------------------------------
module tavg_accum #(
   parameter int SAMPLES = 50
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [7:0]         temp_whole,
   input  logic                      temp_half,
   output logic                      out_valid,
   input  logic                      out_ready,
   output tavg_pkg::avg_word_type    out_word
);

   // exact floor(x / SAMPLES) for x below 2**SCALED_W by reciprocal multiply
   localparam int DIV_SHIFT = tavg_pkg::SCALED_W + $clog2(SAMPLES);
   localparam int MULT_W    = tavg_pkg::SCALED_W + 1;
   localparam int PROD_W    = tavg_pkg::SCALED_W + MULT_W;
   localparam logic [MULT_W-1:0] DIV_MULT =
      MULT_W'(((64'd1 << DIV_SHIFT) + SAMPLES - 1) / SAMPLES);

   logic                              in_v_ff;
   logic signed [7:0]                 whole_ff;
   logic                              half_ff;
   logic signed [tavg_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [tavg_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [tavg_pkg::TENTHS_W-1:0]     tenths_ff, tenths_in;
   logic                              neg_ff, neg_in;
   logic                              led_ff, led_in;
   logic                              out_v_ff;
   tavg_pkg::avg_word_type            word_ff;

   logic                              advance;
   logic                              averaging;
   logic signed [8:0]                 reading;
   logic [tavg_pkg::SUM_W-1:0]        abs_sum;
   logic [tavg_pkg::SCALED_W-1:0]     scaled;
   logic [PROD_W-1:0]                 product;
   logic [tavg_pkg::TENTHS_W-1:0]     quotient;

   assign advance   = in_v_ff && (!out_v_ff || out_ready);
   assign in_ready  = !in_v_ff || advance;
   assign averaging = (count_ff >= tavg_pkg::COUNT_W'(SAMPLES));

   // half-degree units: 2 * whole + half
   assign reading  = {whole_ff, half_ff};
   assign abs_sum  = sum_ff[tavg_pkg::SUM_W-1] ? tavg_pkg::SUM_W'(-sum_ff)
                                               : tavg_pkg::SUM_W'(sum_ff);
   assign scaled   = {1'b0, abs_sum[tavg_pkg::MAG_W-1:0], 2'b00}
                   + tavg_pkg::SCALED_W'(abs_sum[tavg_pkg::MAG_W-1:0]);
   assign product  = PROD_W'(scaled) * PROD_W'(DIV_MULT);
   assign quotient = product[DIV_SHIFT +: tavg_pkg::TENTHS_W];

   always_comb begin
      sum_in    = sum_ff;
      count_in  = count_ff;
      tenths_in = tenths_ff;
      neg_in    = neg_ff;
      led_in    = led_ff;
      if (advance) begin
         if (averaging) begin
            // this reading is dropped; latch the average and restart
            tenths_in = quotient;
            neg_in    = sum_ff[tavg_pkg::SUM_W-1];
            led_in    = !led_ff;
            sum_in    = '0;
            count_in  = '0;
         end else begin
            sum_in   = sum_ff + tavg_pkg::SUM_W'(reading);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         sum_ff    <= '0;
         count_ff  <= '0;
         tenths_ff <= '0;
         neg_ff    <= 1'b0;
         led_ff    <= 1'b0;
      end else begin
         if (in_ready) begin
            in_v_ff <= in_valid;
         end
         if (!out_v_ff || out_ready) begin
            out_v_ff <= in_v_ff;
         end
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         tenths_ff <= tenths_in;
         neg_ff    <= neg_in;
         led_ff    <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         whole_ff <= temp_whole;
         half_ff  <= temp_half;
      end
      if (advance) begin
         word_ff.tenths   <= tenths_in;
         word_ff.negative <= neg_in;
         word_ff.led      <= led_in;
         word_ff.fresh    <= averaging;
      end
   end

   assign out_valid = out_v_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/tavg_display.sv =====
// ----------------------------------------------------------------------------
// tavg_display
// Splits the average into decimal digits, encodes the segments and holds
// the result word until it is taken.
// ----------------------------------------------------------------------------
module tavg_display (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tavg_pkg::avg_word_type        in_word,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [tavg_pkg::SEG_W-1:0]    seg_first,
   output logic [tavg_pkg::SEG_W-1:0]    seg_tens,
   output logic [tavg_pkg::SEG_W-1:0]    seg_ones,
   output logic [tavg_pkg::SEG_W-1:0]    seg_tenths,
   output logic                          led_on,
   output logic                          new_average
);

   logic                           out_v_ff;
   logic [tavg_pkg::SEG_W-1:0]     first_ff, tens_ff, ones_ff, tenths_ff;
   logic                           led_ff, fresh_ff;

   logic [tavg_pkg::DIGIT_W-1:0]   dig_hund, dig_tens, dig_ones, dig_tenths;
   logic [9:0]                     rem_hund;
   logic [9:0]                     base_tens;
   logic [6:0]                     rem_tens;
   logic [6:0]                     base_ones;
   logic [tavg_pkg::SEG_W-1:0]     first_in;

   assign in_ready = !out_v_ff || out_ready;

   always_comb begin
      // magnitude stays below 2000 tenths, so hundreds is zero or one
      dig_hund = (in_word.tenths >= tavg_pkg::TENTHS_W'(1000)) ? 4'd1 : 4'd0;
      rem_hund = (dig_hund != 4'd0) ? 10'(in_word.tenths - tavg_pkg::TENTHS_W'(1000))
                                    : 10'(in_word.tenths);
      dig_tens  = 4'd0;
      base_tens = 10'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem_hund >= 10'(k * 100)) begin
            dig_tens  = 4'(k);
            base_tens = 10'(k * 100);
         end
      end
      rem_tens  = 7'(rem_hund - base_tens);
      dig_ones  = 4'd0;
      base_ones = 7'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem_tens >= 7'(k * 10)) begin
            dig_ones  = 4'(k);
            base_ones = 7'(k * 10);
         end
      end
      dig_tenths = 4'(rem_tens - base_ones);

      if (in_word.negative) begin
         first_in = tavg_pkg::SEG_MINUS;
      end else if (dig_hund == 4'd0) begin
         first_in = tavg_pkg::SEG_BLANK;
      end else begin
         first_in = tavg_pkg::seg_encode(dig_hund);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (in_ready) begin
         out_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         first_ff  <= first_in;
         tens_ff   <= tavg_pkg::seg_encode(dig_tens);
         ones_ff   <= tavg_pkg::seg_encode(dig_ones);
         tenths_ff <= tavg_pkg::seg_encode(dig_tenths);
         led_ff    <= in_word.led;
         fresh_ff  <= in_word.fresh;
      end
   end

   assign out_valid   = out_v_ff;
   assign seg_first   = first_ff;
   assign seg_tens    = tens_ff;
   assign seg_ones    = ones_ff;
   assign seg_tenths  = tenths_ff;
   assign led_on      = led_ff;
   assign new_average = fresh_ff;

endmodule

// ===== rtl/temp_average_to_seven_segment.sv =====
// ----------------------------------------------------------------------------
// temp_average_to_seven_segment
// Averages temperature readings and drives a four-digit seven-segment word.
// ----------------------------------------------------------------------------
// One reading is taken every clock cycle unless the result side stalls, and
// one result word comes back for each reading. The reading is registered at
// the input, the average in tavg_accum, the segments in tavg_display. Each
// reading (whole degrees plus a half-degree flag) is added to a running sum;
// after SAMPLES readings the next one is dropped and instead latches the
// average, truncated to tenths of a degree, toggles the status LED and
// restarts the sum. Every result shows the latched average: minus, blank or
// hundreds digit, then tens, ones and tenths, all active low. The one-cycle
// rate is set by the loop on the running sum and count, which closes through
// a single add; the reciprocal multiply for the divide sits between the sum
// and the latched average.
// ----------------------------------------------------------------------------
module temp_average_to_seven_segment #(
   parameter int SAMPLES = 50
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [7:0]           req_temp_whole,
   input  logic                        req_temp_half,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tavg_pkg::SEG_W-1:0]  rsp_seg_first,
   output logic [tavg_pkg::SEG_W-1:0]  rsp_seg_tens,
   output logic [tavg_pkg::SEG_W-1:0]  rsp_seg_ones,
   output logic [tavg_pkg::SEG_W-1:0]  rsp_seg_tenths,
   output logic                        rsp_led_on,
   output logic                        rsp_new_average
);

   logic                   avg_valid;
   logic                   avg_ready;
   tavg_pkg::avg_word_type avg_word;

   tavg_accum #(
      .SAMPLES (SAMPLES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .temp_whole (req_temp_whole),
      .temp_half  (req_temp_half),
      .out_valid  (avg_valid),
      .out_ready  (avg_ready),
      .out_word   (avg_word)
   );

   tavg_display u_display (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (avg_valid),
      .in_ready    (avg_ready),
      .in_word     (avg_word),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .seg_first   (rsp_seg_first),
      .seg_tens    (rsp_seg_tens),
      .seg_ones    (rsp_seg_ones),
      .seg_tenths  (rsp_seg_tenths),
      .led_on      (rsp_led_on),
      .new_average (rsp_new_average)
   );

endmodule
